@@ rtl/core/sparse_pattern_row_union_core_assert.svh @@
// Assertion macros used by the checker of the sparse pattern row union core
`ifndef SPARSE_PATTERN_ROW_UNION_CORE_ASSERT_SVH
`define SPARSE_PATTERN_ROW_UNION_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPRU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SPRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/spru_pkg.sv @@
// Shared constants, types and helpers of the sparse pattern row union core
`default_nettype none
package spru_pkg;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int MAX_ENTRIES = 1024;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 10;
    localparam int VALUE_W  = 11;
    localparam int CFG_W    = 7;
    localparam int COL_W    = 6;
    localparam int NZ_W     = 7;
    localparam int OFF_W    = 13;
    localparam int RS_AW    = $clog2(MAX_ROWS + 1);
    localparam int COL_AW   = $clog2(MAX_ENTRIES);
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_START = 2'd0,
        OP_LOAD_COL   = 2'd1,
        OP_ADD_ROW    = 2'd2,
        OP_FINISH     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_WALK,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_opcode              opcode;
        logic [SLOT_W-1:0]    slot;
        logic [VALUE_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [NZ_W-1:0]  row_nonzeros;
        logic [OFF_W-1:0] row_offset;
        logic             empty_row;
        logic             last;
    } t_result;

    function automatic logic [COL_W-1:0] lowest_set(input logic [MAX_COLS-1:0] bm);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = MAX_COLS - 1; i >= 0; i--) begin
            if (bm[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/sparse_pattern_row_union_core.sv @@
// Top level of the sparse pattern row union core
// Items enter a four-deep command queue; the back end runs one at a time.
// A load item writes one entry; a neighbor item reads its row bounds, then walks the
// stored entries of that row one at a time (the column store has one read port); a
// finish item emits one result per distinct column, or one empty-row result for an
// empty row, paced by pop through a two-entry result queue. Out-of-range loads and
// skipped neighbors are dropped at the front and cost nothing. No clearing pass after reset.
`default_nettype none
module sparse_pattern_row_union_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [spru_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [spru_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic [spru_pkg::VALUE_W-1:0]  i_value,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [spru_pkg::COL_W-1:0]         o_column,
    output logic [spru_pkg::NZ_W-1:0]          o_row_nonzeros,
    output logic [spru_pkg::OFF_W-1:0]         o_row_offset,
    output logic                               o_empty_row,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spru_pkg::CFG_W-1:0]    i_cfg_data
);
    import spru_pkg::*;

    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    t_result result;

    spru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_opcode   (i_opcode),
        .i_slot     (i_slot),
        .i_value    (i_value),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    spru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_column       = result.column;
    assign o_row_nonzeros = result.row_nonzeros;
    assign o_row_offset   = result.row_offset;
    assign o_empty_row    = result.empty_row;
    assign o_last         = result.last;
endmodule
`default_nettype wire

@@ rtl/core/spru_ram.sv @@
// Generic single write port RAM with one registered read port
`default_nettype none
module spru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/spru_front.sv @@
// Front end: row count register, item classification and command queue
`default_nettype none
module spru_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [spru_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [spru_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic [spru_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spru_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                               o_cmd_valid,
    output spru_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_cmd_pop
);
    import spru_pkg::*;

    logic [CFG_W-1:0] r_row_count;
    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp, r_rp;
    logic [CQ_AW:0]   r_cnt, n_cnt;
    logic             keep, do_push, do_pop;

    assign o_cfg_ready = 1'b1;
    assign o_full      = (r_cnt == (CQ_AW+1)'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        case (t_opcode'(i_opcode))
            OP_LOAD_START: keep = (int'(i_slot) <= MAX_ROWS);
            OP_LOAD_COL:   keep = (int'(i_slot) < MAX_ENTRIES);
            OP_ADD_ROW:    keep = (int'(i_value) < int'(r_row_count))
                                  && (int'(i_value) < MAX_ROWS);
            OP_FINISH:     keep = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    assign do_push = i_push && !o_full && keep;
    assign do_pop  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_W'(MAX_ROWS);
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_row_count <= i_cfg_data;
            end
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= '{opcode: t_opcode'(i_opcode), slot: i_slot, value: i_value};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/spru_back.sv @@
// Back end: pattern tables, row walk, bitmap scan and result queue
`default_nettype none
module spru_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire spru_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                o_empty,
    input  wire logic           i_pop,
    output spru_pkg::t_result   o_result
);
    import spru_pkg::*;

    t_state                r_state, n_state;
    logic [RS_AW-1:0]      r_row;
    logic [VALUE_W-1:0]    r_ptr, r_end;
    logic                  r_rd_v;
    logic [MAX_COLS-1:0]   r_bitmap;
    logic [NZ_W-1:0]       r_count;
    logic [OFF_W-1:0]      r_total;

    logic                  rs_we, col_we;
    logic [RS_AW-1:0]      rs_raddr;
    logic [VALUE_W-1:0]    rs_rdata;
    logic [COL_W-1:0]      col_rdata;
    logic                  walk_go, res_push, oq_full;
    t_result               res;
    logic [MAX_COLS-1:0]   bm_clr;

    t_result               r_oq [2];
    logic                  r_oq_wp, r_oq_rp;
    logic [1:0]            r_oq_cnt;

    spru_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ROWS + 1)) u_row_start (
        .i_clk  (i_clk),
        .i_we   (rs_we),
        .i_waddr(i_cmd.slot[RS_AW-1:0]),
        .i_wdata(i_cmd.value),
        .i_raddr(rs_raddr),
        .o_rdata(rs_rdata)
    );

    spru_ram #(.WIDTH(COL_W), .DEPTH(MAX_ENTRIES)) u_col_store (
        .i_clk  (i_clk),
        .i_we   (col_we),
        .i_waddr(i_cmd.slot[COL_AW-1:0]),
        .i_wdata(i_cmd.value[COL_W-1:0]),
        .i_raddr(r_ptr[COL_AW-1:0]),
        .o_rdata(col_rdata)
    );

    assign oq_full  = (r_oq_cnt == 2'd2);
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rp];
    assign walk_go  = (r_ptr < r_end) && (int'(r_ptr) < MAX_ENTRIES);
    assign bm_clr   = r_bitmap & (r_bitmap - 1'b1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.opcode)
                        OP_ADD_ROW: n_state = S_RD_LO;
                        OP_FINISH:  n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_WALK;
            S_WALK: begin
                if (!walk_go) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!oq_full && (r_count == '0 || bm_clr == '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        rs_we     = 1'b0;
        col_we    = 1'b0;
        rs_raddr  = r_row + 1'b1;
        res_push  = 1'b0;
        res       = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                rs_raddr  = i_cmd.value[RS_AW-1:0];
                rs_we     = i_cmd_valid && (i_cmd.opcode == OP_LOAD_START);
                col_we    = i_cmd_valid && (i_cmd.opcode == OP_LOAD_COL);
            end
            S_SCAN: begin
                res_push       = !oq_full;
                res.row_offset = r_total;
                res.row_nonzeros = r_count;
                if (r_count == '0) begin
                    res.empty_row = 1'b1;
                    res.last      = 1'b1;
                end else begin
                    res.column = lowest_set(r_bitmap);
                    res.last   = (bm_clr == '0);
                end
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_v   <= 1'b0;
            r_bitmap <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_WALK) && walk_go;
            if (r_rd_v && int'(col_rdata) < MAX_COLS && !r_bitmap[col_rdata]) begin
                r_bitmap[col_rdata] <= 1'b1;
                r_count             <= r_count + 1'b1;
            end
            if (r_state == S_SCAN && !oq_full) begin
                if (r_count == '0 || bm_clr == '0) begin
                    r_total  <= r_total + OFF_W'(r_count);
                    r_count  <= '0;
                    r_bitmap <= '0;
                end else begin
                    r_bitmap <= bm_clr;
                end
            end
            if (res_push) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (i_pop && !o_empty) begin
                r_oq_rp <= ~r_oq_rp;
            end
            if (res_push && !(i_pop && !o_empty)) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (!res_push && i_pop && !o_empty) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_row <= i_cmd.value[RS_AW-1:0];
        end
        if (r_state == S_RD_LO) begin
            r_ptr <= rs_rdata;
        end else if (r_state == S_WALK && walk_go) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (r_state == S_RD_HI) begin
            r_end <= rs_rdata;
        end
        if (res_push) begin
            r_oq[r_oq_wp] <= res;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/spru_checker.sv @@
// Port-level checker of the sparse pattern row union core and its bind
`default_nettype none
`include "sparse_pattern_row_union_core_assert.svh"
module spru_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [spru_pkg::NZ_W-1:0]     o_row_nonzeros,
    input  wire logic [spru_pkg::OFF_W-1:0]    o_row_offset,
    input  wire logic                          o_empty_row,
    input  wire logic                          o_last
);
    `SPRU_ASSERT_NOW(a_empty_row_last, !empty && o_empty_row, o_last)
    `SPRU_ASSERT_NOW(a_empty_row_zero, !empty && o_empty_row, o_row_nonzeros == '0)
    `SPRU_ASSERT_NOW(a_full_row_nonzero, !empty && !o_empty_row, o_row_nonzeros != '0)
    `SPRU_ASSERT_NEXT(a_offset_held, pop && !empty && !o_last, empty || o_row_offset == $past(o_row_offset))
endmodule

bind sparse_pattern_row_union_core spru_checker u_spru_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_row_nonzeros(o_row_nonzeros),
    .o_row_offset  (o_row_offset),
    .o_empty_row   (o_empty_row),
    .o_last        (o_last)
);
`default_nettype wire
